### design/sdc_pkg.sv
// Package for the serial day to calendar unit.
// Holds widths, calendar constants, the month length function and the
// result type of the shared subtract/compare unit. No dependencies.
package sdc_pkg;

   // Fixed field widths of the item formats.
   localparam int DAYS_W     = 22;
   localparam int FRAC_IN_W  = 32;
   localparam int YEAR_OUT_W = 13;
   localparam int MON_W      = 4;
   localparam int MDAY_W     = 5;
   localparam int YDAY_W     = 10;
   localparam int WDAY_W     = 3;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;
   localparam int SEC_W      = 6;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   // Defaults for the top level parameters.
   localparam int DEFAULT_FRACTION_BITS  = 32;
   localparam int DEFAULT_MAX_SERIAL_DAY = 2958465;

   // Shared unit width covers the day count and the seconds of a day.
   localparam int ALU_W = 23;

   // Multiplier constant operand width and the time constants.
   localparam int MUL_B_W  = 18;
   localparam int TMIN_W   = 11;
   localparam int TSEC_W   = 17;
   localparam logic [MUL_B_W-1:0] MINUTES_PER_DAY     = 18'd1440;
   localparam logic [MUL_B_W-1:0] HALF_SECONDS_PER_DAY = 18'd172800;
   localparam logic [MUL_B_W-1:0] SECONDS_PER_MINUTE  = 18'd60;

   // Restoring division steps: hour = minutes / 60, weekday = days mod 7.
   localparam int STEP_W    = 5;
   localparam int HOUR_TOP  = 4;
   localparam int WDAY_TOP  = 19;
   localparam logic [ALU_W-1:0] MINUTES_PER_HOUR = 23'd60;
   localparam logic [ALU_W-1:0] DAYS_PER_WEEK    = 23'd7;

   // Calendar constants.
   localparam logic [ALU_W-1:0] DAYS_LEAP_YEAR   = 23'd366;
   localparam logic [ALU_W-1:0] DAYS_COMMON_YEAR = 23'd365;
   localparam logic [8:0]       BASE_YEAR_MOD400 = 9'd300;
   localparam logic [8:0]       LAST_MOD400      = 9'd399;
   localparam logic [6:0]       LAST_MOD100      = 7'd99;
   localparam logic [MON_W-1:0] LAST_MONTH       = 4'd11;
   localparam logic [MON_W-1:0] FEBRUARY         = 4'd1;

   localparam logic [MDAY_W-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Result of the shared subtract/compare unit.
   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             ge;
      logic             gt;
   } alu_res_type;

   // Length of a month; codes past December give zero.
   function automatic logic [MDAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                    input logic leap);
      logic [MDAY_W-1:0] len;
      if (mon > LAST_MONTH) begin
         len = '0;
      end else if (mon == FEBRUARY && leap) begin
         len = 5'd29;
      end else begin
         len = MONTH_LEN[mon];
      end
      return len;
   endfunction

endpackage

### design/serial_day_to_calendar_unit.sv
// Serial day to calendar converter, top level with the sequencer.
// Depends on sdc_pkg, sdc_alu and sdc_mul.
//
// Usage: an item on the req_ channel carries a serial date as whole days
// (day 1 is 1900-01-01, 1900 counted as a leap year) and a day fraction.
// The rsp_ channel returns one item per request with year, month, day of
// month, day of year, weekday and the rounded time of day; rsp_tuser flags
// a day count past the supported maximum, with all other fields zero.
// Sequence: the multiply steps, the seconds step, five hour steps and
// twenty weekday steps, then the year walk, one step per whole year, up
// to eleven month steps and the output step. An out of range item goes
// straight to the output step. Every subtract and compare step goes
// through the one shared subtractor, so the year walk sets the throughput;
// req_tready is high only while the unit is idle.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls; the unit then waits before writing its next result.
// Reset is synchronous and active high; it clears the sequencer and drops
// rsp_tvalid. There is no configuration and no state kept between items.
module serial_day_to_calendar_unit
   import sdc_pkg::*;
#(
   parameter int FRACTION_BITS  = DEFAULT_FRACTION_BITS,
   parameter int MAX_SERIAL_DAY = DEFAULT_MAX_SERIAL_DAY
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata: serial_days[21:0], serial_fraction[53:22], zero pad [55:54]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: year_offset[12:0], month_index[16:13], day_of_month[21:17],
   // day_of_year[31:22], weekday[34:32], hour[39:35], minute[45:40],
   // second[51:46], zero pad [55:52]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: out_of_range[0]
   output logic                  rsp_tuser
);

   localparam int FRAC_W = (FRACTION_BITS < FRAC_IN_W) ? FRACTION_BITS : FRAC_IN_W;
   localparam int PROD_W = FRAC_W + MUL_B_W;
   localparam int YEAR_W = $clog2(MAX_SERIAL_DAY / 365 + 2);
   localparam logic [DAYS_W-1:0] MAX_DAY = DAYS_W'(MAX_SERIAL_DAY);

   // Sequencer codes.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_MIN = 4'd1;
   localparam logic [3:0] S_MUL_SEC = 4'd2;
   localparam logic [3:0] S_MUL_HR  = 4'd3;
   localparam logic [3:0] S_SEC     = 4'd4;
   localparam logic [3:0] S_HOUR    = 4'd5;
   localparam logic [3:0] S_WDAY    = 4'd6;
   localparam logic [3:0] S_YEAR    = 4'd7;
   localparam logic [3:0] S_MONTH   = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   logic [3:0]            state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DAYS_W-1:0]     days_ff, days_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [DAYS_W-1:0]     rem_ff, rem_in;
   logic                  oor_ff, oor_in;
   logic [TMIN_W-1:0]     tmin_ff, tmin_in;
   logic [TSEC_W-1:0]     tsec_ff, tsec_in;
   logic [TSEC_W-1:0]     min60_ff, min60_in;
   logic [SEC_W-1:0]      sec_ff, sec_in;
   logic [HOUR_W-1:0]     hour_ff, hour_in;
   logic [WDAY_W-1:0]     wday_ff, wday_in;
   logic [YEAR_W-1:0]     year_ff, year_in;
   logic [6:0]            mod100_ff, mod100_in;
   logic [8:0]            mod400_ff, mod400_in;
   logic [MON_W-1:0]      mon_ff, mon_in;
   logic [YDAY_W-1:0]     yday_ff, yday_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [DAYS_W-1:0]     req_days;
   logic [FRAC_IN_W-1:0]  req_frac;
   logic                  req_take;
   logic                  leap;
   logic [MDAY_W-1:0]     mlen;
   logic [ALU_W-1:0]      alu_a, alu_b;
   alu_res_type           alu_res;
   logic [FRAC_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [PROD_W-1:0]     prod;
   logic [TSEC_W:0]       half_sec;
   logic [2:0]            rem7;
   logic                  out_free;

   // Carry chain signals of the output cycle.
   logic                  c_sec, c_min, c_hour, c_day, c_mon;
   logic [SEC_W-1:0]      f_sec;
   logic [MIN_W-1:0]      f_min;
   logic [HOUR_W-1:0]     f_hour;
   logic [MDAY_W-1:0]     f_mday;
   logic [MON_W-1:0]      f_mon;
   logic [YEAR_OUT_W-1:0] f_year;
   logic [MIN_W:0]        min_inc;
   logic [HOUR_W:0]       hour_inc;
   logic [MDAY_W:0]       mday_inc;

   assign req_days   = req_tdata[DAYS_W-1:0];
   assign req_frac   = req_tdata[DAYS_W +: FRAC_IN_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Leap rule with 1900 forced leap, from the running year residues.
   assign leap = (year_ff == '0) || (mod400_ff == '0) ||
                 ((year_ff[1:0] == 2'b00) && (mod100_ff != '0));
   assign mlen = month_days(mon_ff, leap);

   // Operand selection for the shared subtractor.
   always_comb begin
      alu_a = ALU_W'(rem_ff);
      alu_b = '0;
      unique case (state_ff)
         S_SEC: begin
            alu_a = ALU_W'(tsec_ff);
            alu_b = ALU_W'(min60_ff);
         end
         S_HOUR: begin
            alu_a = ALU_W'(tmin_ff);
            alu_b = MINUTES_PER_HOUR << step_ff;
         end
         S_WDAY: begin
            alu_b = DAYS_PER_WEEK << step_ff;
         end
         S_YEAR: begin
            alu_b = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
         end
         S_MONTH: begin
            alu_b = ALU_W'(mlen);
         end
         default: begin
            alu_b = '0;
         end
      endcase
   end

   sdc_alu u_alu (
      .opa (alu_a),
      .opb (alu_b),
      .res (alu_res)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = frac_ff;
      mul_b = MINUTES_PER_DAY;
      if (state_ff == S_MUL_SEC) begin
         mul_b = HALF_SECONDS_PER_DAY;
      end else if (state_ff == S_MUL_HR) begin
         mul_a = FRAC_W'(tmin_ff);
         mul_b = SECONDS_PER_MINUTE;
      end
   end

   sdc_mul #(
      .A_W (FRAC_W)
   ) u_mul (
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Rounded seconds: half seconds of the day plus one, halved.
   assign half_sec = (TSEC_W+1)'(prod >> FRACTION_BITS) + (TSEC_W+1)'(1);

   // Last weekday residue after the final restoring step.
   assign rem7 = alu_res.ge ? alu_res.diff[2:0] : rem_ff[2:0];

   // Carry of a rounded sixtieth second through the calendar fields.
   always_comb begin
      c_sec    = (sec_ff >= SEC_W'(60));
      f_sec    = c_sec ? sec_ff - SEC_W'(60) : sec_ff;
      min_inc  = (MIN_W+1)'(tmin_ff) + (MIN_W+1)'(c_sec);
      c_min    = (min_inc >= (MIN_W+1)'(60));
      f_min    = c_min ? MIN_W'(min_inc - (MIN_W+1)'(60)) : MIN_W'(min_inc);
      hour_inc = (HOUR_W+1)'(hour_ff) + (HOUR_W+1)'(c_min);
      c_hour   = (hour_inc >= (HOUR_W+1)'(24));
      f_hour   = c_hour ? HOUR_W'(hour_inc - (HOUR_W+1)'(24)) : HOUR_W'(hour_inc);
      mday_inc = (MDAY_W+1)'(rem_ff[MDAY_W-1:0]) + (MDAY_W+1)'(c_hour);
      c_day    = (mday_inc > (MDAY_W+1)'(mlen));
      f_mday   = c_day ? MDAY_W'(1) : MDAY_W'(mday_inc);
      c_mon    = c_day && (mon_ff == LAST_MONTH);
      f_mon    = c_mon ? '0 : (c_day ? mon_ff + MON_W'(1) : mon_ff);
      f_year   = YEAR_OUT_W'(year_ff) + YEAR_OUT_W'(c_mon);
   end

   // Sequencer and datapath registers.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      days_in      = days_ff;
      frac_in      = frac_ff;
      rem_in       = rem_ff;
      oor_in       = oor_ff;
      tmin_in      = tmin_ff;
      tsec_in      = tsec_ff;
      min60_in     = min60_ff;
      sec_in       = sec_ff;
      hour_in      = hour_ff;
      wday_in      = wday_ff;
      year_in      = year_ff;
      mod100_in    = mod100_ff;
      mod400_in    = mod400_ff;
      mon_in       = mon_ff;
      yday_in      = yday_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               days_in   = req_days;
               frac_in   = req_frac[FRAC_W-1:0];
               rem_in    = req_days;
               oor_in    = (req_days > MAX_DAY);
               year_in   = '0;
               mod100_in = '0;
               mod400_in = BASE_YEAR_MOD400;
               mon_in    = '0;
               state_in  = (req_days > MAX_DAY) ? S_DONE : S_MUL_MIN;
            end
         end
         S_MUL_MIN: begin
            tmin_in  = TMIN_W'(prod >> FRACTION_BITS);
            state_in = S_MUL_SEC;
         end
         S_MUL_SEC: begin
            tsec_in  = half_sec[TSEC_W:1];
            state_in = S_MUL_HR;
         end
         S_MUL_HR: begin
            min60_in = prod[TSEC_W-1:0];
            state_in = S_SEC;
         end
         S_SEC: begin
            sec_in   = alu_res.diff[SEC_W-1:0];
            hour_in  = '0;
            step_in  = STEP_W'(HOUR_TOP);
            state_in = S_HOUR;
         end
         S_HOUR: begin
            // One quotient bit of minutes / 60 per cycle.
            hour_in = {hour_ff[HOUR_W-2:0], alu_res.ge};
            if (alu_res.ge) begin
               tmin_in = alu_res.diff[TMIN_W-1:0];
            end
            if (step_ff == '0) begin
               step_in  = STEP_W'(WDAY_TOP);
               state_in = S_WDAY;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_WDAY: begin
            // Days mod 7 by restoring subtraction of shifted multiples.
            if (alu_res.ge) begin
               rem_in = alu_res.diff[DAYS_W-1:0];
            end
            if (step_ff == '0) begin
               wday_in  = (rem7 == 3'd0) ? 3'd6 : rem7 - 3'd1;
               rem_in   = days_ff;
               state_in = S_YEAR;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         S_YEAR: begin
            // One whole year per cycle while the remainder exceeds it.
            if (alu_res.gt) begin
               rem_in    = alu_res.diff[DAYS_W-1:0];
               year_in   = year_ff + YEAR_W'(1);
               mod100_in = (mod100_ff == LAST_MOD100) ? '0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == LAST_MOD400) ? '0 : mod400_ff + 9'd1;
            end else begin
               yday_in  = rem_ff[YDAY_W-1:0] - YDAY_W'(1);
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            if (mon_ff == LAST_MONTH || !alu_res.gt) begin
               state_in = S_DONE;
            end else begin
               rem_in = alu_res.diff[DAYS_W-1:0];
               mon_in = mon_ff + MON_W'(1);
            end
         end
         S_DONE: begin
            // Write the result once the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = oor_ff;
               if (oor_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = {4'b0000, f_sec, f_min, f_hour, wday_ff, yday_ff,
                                 f_mday, f_mon, f_year};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      days_ff     <= days_in;
      frac_ff     <= frac_in;
      rem_ff      <= rem_in;
      oor_ff      <= oor_in;
      tmin_ff     <= tmin_in;
      tsec_ff     <= tsec_in;
      min60_ff    <= min60_in;
      sec_ff      <= sec_in;
      hour_ff     <= hour_in;
      wday_ff     <= wday_in;
      year_ff     <= year_in;
      mod100_ff   <= mod100_in;
      mod400_ff   <= mod400_in;
      mon_ff      <= mon_in;
      yday_ff     <= yday_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

### design/sdc_alu.sv
// Shared subtract and compare unit of the serial day to calendar unit.
// Depends on sdc_pkg for the unit width and the result type.
module sdc_alu
   import sdc_pkg::*;
(
   input  logic [ALU_W-1:0] opa,
   input  logic [ALU_W-1:0] opb,
   output alu_res_type      res
);

   logic [ALU_W:0] wide_diff;

   // One subtraction; the borrow gives the compare results.
   always_comb begin
      wide_diff = {1'b0, opa} - {1'b0, opb};
      res.diff  = wide_diff[ALU_W-1:0];
      res.ge    = ~wide_diff[ALU_W];
      res.gt    = ~wide_diff[ALU_W] && (wide_diff[ALU_W-1:0] != '0);
   end

endmodule

### design/sdc_mul.sv
// Shared multiplier of the serial day to calendar unit: a variable operand
// times a constant chosen by the sequencer. Depends on sdc_pkg.
module sdc_mul
   import sdc_pkg::*;
#(
   parameter int A_W = FRAC_IN_W
)
(
   input  logic [A_W-1:0]         mul_a,
   input  logic [MUL_B_W-1:0]     mul_b,
   output logic [A_W+MUL_B_W-1:0] prod
);

   // Unsigned product at full width.
   assign prod = (A_W+MUL_B_W)'(mul_a) * (A_W+MUL_B_W)'(mul_b);

endmodule

### bench/tb_serial_day_to_calendar_unit.sv
// Testbench for serial_day_to_calendar_unit: drives serial dates on the req_ stream
// and checks every rsp_ item against a calendar predictor built into the bench.
// Depends on sdc_pkg and the serial_day_to_calendar_unit RTL.
module tb_serial_day_to_calendar_unit;
   import sdc_pkg::*;

   localparam int MAX_DAY     = DEFAULT_MAX_SERIAL_DAY;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int HOLD_CYCLES = 1500;
   localparam int PRINT_LIMIT = 40;
   localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // One result item as it appears on {rsp_tuser, rsp_tdata}.
   typedef struct packed {
      logic                  out_of_range;
      logic [3:0]            zero_pad;
      logic [SEC_W-1:0]      second;
      logic [MIN_W-1:0]      minute;
      logic [HOUR_W-1:0]     hour;
      logic [WDAY_W-1:0]     weekday;
      logic [YDAY_W-1:0]     day_of_year;
      logic [MDAY_W-1:0]     day_of_month;
      logic [MON_W-1:0]      month_index;
      logic [YEAR_OUT_W-1:0] year_offset;
   } calendar_type;

   typedef struct {
      logic [DAYS_W-1:0]    days;
      logic [FRAC_IN_W-1:0] frac;
      calendar_type         fields;
   } expected_date_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   expected_date_type pending_dates[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             stall_left = 0;
   logic           output_idling = 1'b0;
   logic           hold_output = 1'b0;
   bit             input_gaps = 1'b0;

   serial_day_to_calendar_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit in case the unit hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // 1900 counts as a leap year, the rest follow the Gregorian rule.
   function automatic bit is_leap_year(input int unsigned year);
      if (year == 1900) return 1'b1;
      return (year % 400 == 0) || (year % 4 == 0 && year % 100 != 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned mon, input int unsigned year);
      if (mon > 11) return 0;
      if (mon == 1 && is_leap_year(year)) return 29;
      return DAYS_IN_MONTH[mon];
   endfunction

   // Calendar and time-of-day fields for one serial date.
   function automatic calendar_type predict_calendar(input logic [DAYS_W-1:0] days,
                                                     input logic [FRAC_IN_W-1:0] frac);
      calendar_type    c;
      int unsigned     year, mon, mday, yday, wday, hour, minute, second, i;
      longint unsigned rem, frac_l, tot_min, tot_sec;
      c = '0;
      if (days > MAX_DAY) begin
         c.out_of_range = 1'b1;
         return c;
      end

      // Walk whole years, then months, while the remainder exceeds the length.
      rem  = 64'(days);
      year = 0;
      mon  = 0;
      while (rem > (is_leap_year(1900 + year) ? 366 : 365)) begin
         rem -= is_leap_year(1900 + year) ? 366 : 365;
         year++;
      end
      while (mon < 11 && rem > month_length(mon, 1900 + year)) begin
         rem -= month_length(mon, 1900 + year);
         mon++;
      end
      mday = 32'(rem);
      yday = mday - 1;
      for (i = 0; i < mon; i++) yday += month_length(i, 1900 + year);

      wday = days % 7;
      wday = (wday == 0) ? 6 : wday - 1;

      // Minutes truncate, seconds round half up.
      frac_l  = 64'(frac);
      tot_min = (frac_l * 1440) >> 32;
      tot_sec = (frac_l * 172800 + (64'd1 << 32)) >> 33;
      hour    = 32'(tot_min / 60);
      minute  = 32'(tot_min % 60);
      second  = 32'(tot_sec - tot_min * 60);

      // A rounded 60th second ripples up; weekday and day of year stay.
      if (second >= 60) begin
         second -= 60;
         minute++;
         if (minute >= 60) begin
            minute -= 60;
            hour++;
            if (hour >= 24) begin
               hour -= 24;
               mday++;
               if (mday > month_length(mon, 1900 + year)) begin
                  mday = 1;
                  mon++;
                  if (mon > 11) begin
                     mon = 0;
                     year++;
                  end
               end
            end
         end
      end

      c.year_offset  = year[YEAR_OUT_W-1:0];
      c.month_index  = mon[MON_W-1:0];
      c.day_of_month = mday[MDAY_W-1:0];
      c.day_of_year  = yday[YDAY_W-1:0];
      c.weekday      = wday[WDAY_W-1:0];
      c.hour         = hour[HOUR_W-1:0];
      c.minute       = minute[MIN_W-1:0];
      c.second       = second[SEC_W-1:0];
      return c;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want,
                                  input expected_date_type e);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d, days %0d frac %h: %s got %0d expected %0d",
                  cycle_count, e.days, e.frac, what, got, want);
      error_count++;
   endtask

   task automatic check_calendar(input expected_date_type e, input calendar_type got);
      calendar_type w;
      w = e.fields;
      if (got.year_offset !== w.year_offset)
         report_mismatch("year_offset", got.year_offset, w.year_offset, e);
      if (got.month_index !== w.month_index)
         report_mismatch("month_index", got.month_index, w.month_index, e);
      if (got.day_of_month !== w.day_of_month)
         report_mismatch("day_of_month", got.day_of_month, w.day_of_month, e);
      if (got.day_of_year !== w.day_of_year)
         report_mismatch("day_of_year", $signed(got.day_of_year), $signed(w.day_of_year), e);
      if (got.weekday !== w.weekday)
         report_mismatch("weekday", got.weekday, w.weekday, e);
      if (got.hour !== w.hour)
         report_mismatch("hour", got.hour, w.hour, e);
      if (got.minute !== w.minute)
         report_mismatch("minute", got.minute, w.minute, e);
      if (got.second !== w.second)
         report_mismatch("second", got.second, w.second, e);
      if (got.zero_pad !== w.zero_pad)
         report_mismatch("zero_pad", got.zero_pad, w.zero_pad, e);
      if (got.out_of_range !== w.out_of_range)
         report_mismatch("out_of_range", got.out_of_range, w.out_of_range, e);
   endtask

   // Result checker: every accepted rsp_ item is matched to the oldest request.
   always @(posedge clock) begin
      expected_date_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dates.size() == 0) begin
            e.days   = '0;
            e.frac   = '0;
            e.fields = '0;
            report_mismatch("item with nothing pending", 1, 0, e);
         end else begin
            e = pending_dates.pop_front();
            check_calendar(e, calendar_type'({rsp_tuser, rsp_tdata}));
         end
      end
   end

   // Receiver: random stall bursts, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_output) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (output_idling && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offers one item and returns at the edge where it is accepted.
   task automatic send_date(input logic [DAYS_W-1:0] days, input logic [FRAC_IN_W-1:0] frac);
      expected_date_type e;
      if (input_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, frac, days};
      do @(posedge clock); while (!req_tready);
      e.days   = days;
      e.frac   = frac;
      e.fields = predict_calendar(days, frac);
      pending_dates.push_back(e);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_results_drained();
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DAYS_W-1:0] pick_serial_days();
      case ($urandom_range(0, 9))
         5:       return DAYS_W'($urandom_range(0, MAX_DAY));
         6:       return DAYS_W'($urandom_range(MAX_DAY + 1, 4194303));
         7:       return DAYS_W'($urandom_range(MAX_DAY - 400, MAX_DAY));
         default: return DAYS_W'($urandom_range(0, 45000));
      endcase
   endfunction

   function automatic logic [FRAC_IN_W-1:0] pick_fraction();
      case ($urandom_range(0, 3))
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 30000);
         2:       return $urandom_range(0, 50000);
         default: return $urandom();
      endcase
   endfunction

   // Calendar edges, rounding edges and the range limit.
   task automatic test_directed_dates();
      input_gaps = 1'b1;
      send_date(0, 0);
      send_date(0, 32'hFFFF_FFFF);
      send_date(1, 0);
      send_date(59, 0);
      send_date(60, 32'h8000_0000);
      send_date(61, 0);
      send_date(31, 32'hFFFF_FFFF);
      send_date(366, 0);
      send_date(366, 32'hFFFF_FFFF);
      send_date(367, 24855);
      send_date(1521, 24856);
      send_date(36585, 32'h4000_0000);
      send_date(73109, 32'hFFFF_FFFF);
      send_date(73110, 32'hFFFF_A000);
      send_date(45000, 32'h0AAA_AAAB);
      send_date(DAYS_W'(MAX_DAY), 0);
      send_date(DAYS_W'(MAX_DAY), 32'hFFFF_FFFF);
      send_date(DAYS_W'(MAX_DAY + 1), 32'h5555_5555);
      send_date(22'h3FFFFF, 32'hFFFF_FFFF);
      send_date(22'h155555, 32'hAAAA_AAAA);
      stop_sending();
      wait_results_drained();
   endtask

   task automatic test_random_dates(input int count);
      input_gaps = 1'b1;
      output_idling <= 1'b1;
      repeat (count) send_date(pick_serial_days(), pick_fraction());
      stop_sending();
      wait_results_drained();
   endtask

   // Receiver holds off while items keep coming, so the unit backs up.
   task automatic test_output_backpressure();
      input_gaps = 1'b0;
      output_idling <= 1'b0;
      fork
         begin
            hold_output <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output <= 1'b0;
         end
         begin
            repeat (8) send_date(DAYS_W'($urandom_range(0, 3000)), $urandom());
            stop_sending();
         end
      join
      wait_results_drained();
   endtask

   // Sender waits for every result before each short burst.
   task automatic test_paused_bursts();
      input_gaps = 1'b1;
      output_idling <= 1'b1;
      repeat (3) begin
         repeat (3) send_date(pick_serial_days(), pick_fraction());
         stop_sending();
         wait_results_drained();
      end
   endtask

   // Closing stretch with both sides always ready.
   task automatic test_back_to_back(input int count);
      input_gaps = 1'b0;
      output_idling <= 1'b0;
      repeat (count) send_date(DAYS_W'($urandom_range(0, 45000)), pick_fraction());
      stop_sending();
      wait_results_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_random_dates(40);
      test_output_backpressure();
      test_paused_bursts();
      test_back_to_back(25);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_dates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
design/sdc_pkg.sv
design/sdc_alu.sv
design/sdc_mul.sv
design/serial_day_to_calendar_unit.sv
bench/tb_serial_day_to_calendar_unit.sv
